// ===== rtl/bpwm_pkg.sv =====
package bpwm_pkg;

  // default widths of the counters and of the burst count
  localparam int unsigned DefCountWidth = 16;
  localparam int unsigned DefBurstWidth = 24;

  // fixed widths of the clock divider and of the configuration port
  localparam int unsigned DivWidth    = 12;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;

  // configuration register indexes
  localparam logic [CfgIdxWidth-1:0] CfgPrescale = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgPeriod   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgDuty     = 2'd2;

  // configuration reset values (prescale 1 stored as divider last count 0)
  localparam logic [DivWidth-1:0] DivLastReset = 12'd0;
  localparam logic [CfgWidth-1:0] PeriodReset  = 16'd1000;
  localparam logic [CfgWidth-1:0] DutyReset    = 16'd500;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpStart = 2'd1,
    OpCont  = 2'd2,
    OpStop  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ModeIdle  = 2'd0,
    ModeBurst = 2'd1,
    ModeCont  = 2'd2
  } mode_e;

  // run control passed between the step logic and the state registers
  typedef struct packed {
    mode_e mode;
    logic  done;
  } ctrl_t;

endpackage

// ===== rtl/bpwm_if.sv =====
// command channel
interface bpwm_in_if #(
  parameter int unsigned BURST_WIDTH = bpwm_pkg::DefBurstWidth
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [BURST_WIDTH-1:0] burst_periods;

  modport source (output valid, opcode, burst_periods, input ready);
  modport sink   (input valid, opcode, burst_periods, output ready);
endinterface

// result channel
interface bpwm_out_if #(
  parameter int unsigned BURST_WIDTH = bpwm_pkg::DefBurstWidth
);
  logic                   valid;
  logic                   ready;
  logic                   pwm_level;
  logic                   running;
  logic                   arrived;
  logic [BURST_WIDTH-1:0] remaining_periods;

  modport source (output valid, pwm_level, running, arrived, remaining_periods, input ready);
  modport sink   (input valid, pwm_level, running, arrived, remaining_periods, output ready);
endinterface

// ===== rtl/bpwm_step.sv =====
module bpwm_step #(
  parameter int unsigned COUNT_WIDTH = bpwm_pkg::DefCountWidth,
  parameter int unsigned BURST_WIDTH = bpwm_pkg::DefBurstWidth
) (
  input  bpwm_pkg::opcode_e                op_i,
  input  logic [BURST_WIDTH-1:0]           count_i,
  input  logic [bpwm_pkg::DivWidth-1:0]    div_last_i,
  input  logic [bpwm_pkg::CfgWidth-1:0]    period_i,
  input  logic [bpwm_pkg::CfgWidth-1:0]    duty_i,
  input  logic [bpwm_pkg::DivWidth-1:0]    div_i,
  input  logic [COUNT_WIDTH-1:0]           step_i,
  input  logic [BURST_WIDTH-1:0]           left_i,
  input  bpwm_pkg::ctrl_t                  ctrl_i,
  output logic [bpwm_pkg::DivWidth-1:0]    div_o,
  output logic [COUNT_WIDTH-1:0]           step_o,
  output logic [BURST_WIDTH-1:0]           left_o,
  output bpwm_pkg::ctrl_t                  ctrl_o,
  output logic                             pwm_level_o
);
  import bpwm_pkg::*;

  // compare width covers both the step counter and the 16-bit registers, plus a carry
  localparam int unsigned CmpW = ((COUNT_WIDTH > CfgWidth) ? COUNT_WIDTH : CfgWidth) + 1;
  localparam int unsigned PerW = (COUNT_WIDTH < CfgWidth) ? COUNT_WIDTH : CfgWidth;

  logic [CmpW-1:0]        per_raw;
  logic [CmpW-1:0]        per_eff;
  logic [CmpW-1:0]        step_inc;
  logic [BURST_WIDTH-1:0] left_dec;
  logic                   halt;

  // period masked to the narrower of the counter and register widths, zero acts as one step
  assign per_raw  = CmpW'(period_i[PerW-1:0]);
  assign per_eff  = (per_raw == '0) ? CmpW'(1) : per_raw;
  assign step_inc = CmpW'(step_i) + CmpW'(1);
  assign left_dec = (left_i != '0) ? left_i - BURST_WIDTH'(1) : left_i;

  // next state for one command
  always_comb begin
    div_o  = div_i;
    step_o = step_i;
    left_o = left_i;
    ctrl_o = ctrl_i;
    halt   = 1'b0;
    case (op_i)
      OpTick: begin
        if (ctrl_i.mode != ModeIdle) begin
          if (div_i < div_last_i) begin
            div_o = div_i + DivWidth'(1);
          end else begin
            div_o = '0;
            if (step_inc < per_eff) begin
              step_o = step_inc[COUNT_WIDTH-1:0];
            end else begin
              // end of one pwm period
              step_o = '0;
              if (ctrl_i.mode == ModeBurst) begin
                left_o = left_dec;
                if (left_dec == '0) begin
                  halt = 1'b1;
                end
              end
            end
          end
        end
      end
      OpStart: begin
        if (count_i == '0) begin
          halt = 1'b1;
        end else begin
          ctrl_o.mode = ModeBurst;
          ctrl_o.done = 1'b0;
          div_o       = '0;
          step_o      = '0;
          left_o      = count_i;
        end
      end
      OpCont: begin
        ctrl_o.mode = ModeCont;
        ctrl_o.done = 1'b0;
        left_o      = '0;
      end
      default: begin
        halt = 1'b1;
      end
    endcase
    if (halt) begin
      ctrl_o.mode = ModeIdle;
      ctrl_o.done = 1'b1;
      div_o       = '0;
      step_o      = '0;
      left_o      = '0;
    end
  end

  // output level after the command
  assign pwm_level_o = (ctrl_o.mode != ModeIdle) && (CmpW'(step_o) < CmpW'(duty_i));

endmodule

// ===== rtl/burst_pwm_generator_core.sv =====
// Burst PWM generator. Each command beat (tick, start burst, run continuous, stop)
// yields exactly one result beat with the pin level, the running and arrived flags
// and the periods still to emit. One beat is taken every clock cycle unless a full
// result register stalls: divider, step counter and burst count are updated by a single
// pass of logic feeding that register, and the command side stays ready whenever it is
// empty or drains in the same cycle. Configuration (prescale, period, duty) goes through
// a plain write port; the user must write it only while the block is idle, which the
// block does not enforce. A start burst of zero periods acts as stop.
module burst_pwm_generator_core #(
  parameter int unsigned COUNT_WIDTH = bpwm_pkg::DefCountWidth,
  parameter int unsigned BURST_WIDTH = bpwm_pkg::DefBurstWidth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bpwm_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [bpwm_pkg::CfgWidth-1:0]        cfg_data_i,
  bpwm_in_if.sink                              in_i,
  bpwm_out_if.source                           out_o
);
  import bpwm_pkg::*;

  logic [DivWidth-1:0]    div_last_q;
  logic [CfgWidth-1:0]    period_q;
  logic [CfgWidth-1:0]    duty_q;

  logic [DivWidth-1:0]    div_q, div_d;
  logic [COUNT_WIDTH-1:0] step_q, step_d;
  logic [BURST_WIDTH-1:0] left_q, left_d;
  ctrl_t                  ctrl_q, ctrl_d;
  logic                   pwm_d;

  logic                   out_valid_q;
  logic                   pwm_q;
  logic                   running_q;
  logic                   arrived_q;
  logic [BURST_WIDTH-1:0] remaining_q;
  logic                   in_beat;

  // configuration registers, prescale kept as the divider last count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_last_q <= DivLastReset;
      period_q   <= PeriodReset;
      duty_q     <= DutyReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgPrescale: div_last_q <= cfg_data_i[DivWidth-1:0] - DivWidth'(1);
        CfgPeriod:   period_q   <= cfg_data_i;
        CfgDuty:     duty_q     <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  // command side is free when the result register is empty or drains now
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_beat    = in_i.valid && in_i.ready;

  bpwm_step #(
    .COUNT_WIDTH(COUNT_WIDTH),
    .BURST_WIDTH(BURST_WIDTH)
  ) u_step (
    .op_i       (opcode_e'(in_i.opcode)),
    .count_i    (in_i.burst_periods),
    .div_last_i (div_last_q),
    .period_i   (period_q),
    .duty_i     (duty_q),
    .div_i      (div_q),
    .step_i     (step_q),
    .left_i     (left_q),
    .ctrl_i     (ctrl_q),
    .div_o      (div_d),
    .step_o     (step_d),
    .left_o     (left_d),
    .ctrl_o     (ctrl_d),
    .pwm_level_o(pwm_d)
  );

  // generator state, updated on every command beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_q       <= '0;
      step_q      <= '0;
      left_q      <= '0;
      ctrl_q.mode <= ModeIdle;
      ctrl_q.done <= 1'b1;
    end else if (in_beat) begin
      div_q  <= div_d;
      step_q <= step_d;
      left_q <= left_d;
      ctrl_q <= ctrl_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_beat) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      pwm_q       <= pwm_d;
      running_q   <= (ctrl_d.mode != ModeIdle);
      arrived_q   <= ctrl_d.done;
      remaining_q <= left_d;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.pwm_level         = pwm_q;
  assign out_o.running           = running_q;
  assign out_o.arrived           = arrived_q;
  assign out_o.remaining_periods = remaining_q;

endmodule

// ===== rtl/bpwm_checker.sv =====
module bpwm_props #(
  parameter int unsigned BURST_WIDTH = bpwm_pkg::DefBurstWidth
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic [1:0]             in_opcode_i,
  input logic [BURST_WIDTH-1:0] in_burst_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic                   out_pwm_i,
  input logic                   out_running_i,
  input logic                   out_arrived_i,
  input logic [BURST_WIDTH-1:0] out_remaining_i
);
  import bpwm_pkg::*;

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_remaining_i)
      && $stable(out_pwm_i) && $stable(out_running_i) && $stable(out_arrived_i))
    else $error("stalled result beat changed");

  // command side never blocks when the result register can take a beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("command side stalled without back pressure");

  // arrived is exactly the opposite of running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_running_i != out_arrived_i))
    else $error("arrived and running disagree");

  // idle output is low with no periods pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_running_i |-> !out_pwm_i && (out_remaining_i == '0))
    else $error("idle result shows activity");

  // a start burst shows its full count in the next result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == OpStart) && (in_burst_i != '0)
      |=> out_valid_i && out_running_i && (out_remaining_i == $past(in_burst_i)))
    else $error("start burst count not shown");

endmodule

bind burst_pwm_generator_core bpwm_props #(
  .BURST_WIDTH(BURST_WIDTH)
) u_bpwm_props (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_opcode_i    (in_i.opcode),
  .in_burst_i     (in_i.burst_periods),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_pwm_i      (out_o.pwm_level),
  .out_running_i  (out_o.running),
  .out_arrived_i  (out_o.arrived),
  .out_remaining_i(out_o.remaining_periods)
);
